/* sv/keyed_window_matcher_assert.svh */
// Assertion macros for the keyed window matcher.
`ifndef KEYED_WINDOW_MATCHER_ASSERT_SVH
`define KEYED_WINDOW_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define KWM_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
`define KWM_ASSERT_NORST(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`else
`define KWM_ASSERT(label, clk_s, rst_s, prop)
`define KWM_ASSERT_NORST(label, clk_s, prop)
`endif
`endif

/* sv/kwm_pkg.sv */
// Shared types and constants for the keyed window matcher.
`default_nettype none
package kwm_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [31:0] WindowReset = 32'd259200;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PROBE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_MATCHED = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic              key_present;
    logic [63:0]       ref_key;
    logic signed [47:0] amount;
    logic [39:0]       stamp;
    logic [31:0]       record_id;
  } word_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        probe_id;
    logic [31:0]        partner_id;
    logic signed [47:0] match_amount;
    logic [39:0]        time_delta;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_READ = 3'd1,
    BK_TEST = 3'd2,
    BK_OUT  = 3'd3
  } back_state_t;
endpackage
`default_nettype wire

/* sv/kwm_front.sv */
// Front part: takes input words, drops unused kinds, queues the rest.
`default_nettype none
module kwm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire kwm_pkg::word_t in_word,
  output logic                q_valid,
  input  wire logic           q_take,
  output kwm_pkg::word_t      q_word
);
  kwm_pkg::word_t slots [kwm_pkg::QDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_stall = (count == 2'(kwm_pkg::QDepth));
  // kind 3 words are taken and dropped here
  assign push = in_valid && !in_stall && (in_word.kind != kwm_pkg::KIND_NONE);
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_take;
  assign q_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `include "keyed_window_matcher_assert.svh"
  `KWM_ASSERT(a_cnt_max, clk, rst, count <= 2'(kwm_pkg::QDepth))
  `KWM_ASSERT(a_no_push_full, clk, rst, (count == 2'(kwm_pkg::QDepth)) |-> !push)
  `KWM_ASSERT(a_pop_drop, clk, rst, (pop && !push) |=> (count == $past(count) - 2'd1))
endmodule
`default_nettype wire

/* sv/kwm_back.sv */
// Back part: table memory, load, clear and sequential probe scan.
`default_nettype none
module kwm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      time_window,
  input  wire logic             q_valid,
  output logic                  q_take,
  input  wire kwm_pkg::word_t   q_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kwm_pkg::result_t      out_res
);
  localparam int W = 64 + 48 + 40 + 32;
  logic [W-1:0] mem [kwm_pkg::TableDepth];
  logic [W-1:0] rd_data;
  logic [kwm_pkg::TableDepth-1:0] used;
  logic [kwm_pkg::CntW-1:0] fill_count;
  logic [kwm_pkg::CntW-1:0] scan, scan_next;
  kwm_pkg::back_state_t state, state_next;
  kwm_pkg::word_t cur;
  kwm_pkg::result_t res, res_next;
  logic mem_we, set_used, do_clear, take_cur;
  logic [39:0] dt, es;
  logic [kwm_pkg::IdxW-1:0] hit_idx;
  logic hit;

  assign es = rd_data[71:32];
  assign dt = (es >= cur.stamp) ? es - cur.stamp : cur.stamp - es;
  assign hit_idx = scan[kwm_pkg::IdxW-1:0];
  assign hit = !used[hit_idx] && (rd_data[W-1:120] == cur.ref_key)
            && (rd_data[119:72] == cur.amount) && (dt <= {8'd0, time_window});
  assign out_valid = (state == kwm_pkg::BK_OUT);
  assign out_res = res;

  always_comb begin
    state_next = state;
    scan_next = scan;
    res_next = res;
    q_take = 1'b0;
    take_cur = 1'b0;
    mem_we = 1'b0;
    set_used = 1'b0;
    do_clear = 1'b0;
    case (state)
      kwm_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          take_cur = 1'b1;
          res_next = '0;
          scan_next = '0;
          case (q_word.kind)
            kwm_pkg::KIND_LOAD: begin
              res_next.status = kwm_pkg::ST_LOADED;
              if (q_word.key_present) begin
                if (fill_count == kwm_pkg::CntW'(kwm_pkg::TableDepth)) begin
                  res_next.status = kwm_pkg::ST_FULL;
                end else begin
                  mem_we = 1'b1;
                end
              end
              state_next = kwm_pkg::BK_OUT;
            end
            kwm_pkg::KIND_PROBE: begin
              res_next.status = kwm_pkg::ST_NOMATCH;
              if (q_word.key_present && fill_count != '0) begin
                state_next = kwm_pkg::BK_READ;
              end else begin
                state_next = kwm_pkg::BK_OUT;
              end
            end
            default: begin
              do_clear = 1'b1;
              res_next.status = kwm_pkg::ST_CLEARED;
              state_next = kwm_pkg::BK_OUT;
            end
          endcase
        end
      end
      kwm_pkg::BK_READ: begin
        state_next = kwm_pkg::BK_TEST;
      end
      kwm_pkg::BK_TEST: begin
        if (hit) begin
          set_used = 1'b1;
          res_next.status = kwm_pkg::ST_MATCHED;
          res_next.probe_id = cur.record_id;
          res_next.partner_id = rd_data[31:0];
          res_next.match_amount = cur.amount;
          res_next.time_delta = dt;
          state_next = kwm_pkg::BK_OUT;
        end else if (scan + 1'b1 >= fill_count) begin
          state_next = kwm_pkg::BK_OUT;
        end else begin
          scan_next = scan + 1'b1;
          state_next = kwm_pkg::BK_READ;
        end
      end
      kwm_pkg::BK_OUT: begin
        if (!out_stall) state_next = kwm_pkg::BK_IDLE;
      end
      default: state_next = kwm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_count[kwm_pkg::IdxW-1:0]] <=
        {q_word.ref_key, q_word.amount, q_word.stamp, q_word.record_id};
    end
    rd_data <= mem[scan_next[kwm_pkg::IdxW-1:0]];
    if (take_cur) cur <= q_word;
    res <= res_next;
    scan <= scan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::BK_IDLE;
      used <= '0;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (do_clear) begin
        used <= '0;
        fill_count <= '0;
      end
      if (mem_we) begin
        used[fill_count[kwm_pkg::IdxW-1:0]] <= 1'b0;
        fill_count <= fill_count + 1'b1;
      end
      if (set_used) used[hit_idx] <= 1'b1;
    end
  end

  `include "keyed_window_matcher_assert.svh"
  `KWM_ASSERT(a_fill_max, clk, rst, fill_count <= kwm_pkg::CntW'(kwm_pkg::TableDepth))
  `KWM_ASSERT(a_scan_in, clk, rst, (state == kwm_pkg::BK_TEST) |-> (scan < fill_count))
  `KWM_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(res)))
  `KWM_ASSERT(a_take_idle, clk, rst, q_take |-> (state == kwm_pkg::BK_IDLE))
endmodule
`default_nettype wire

/* sv/keyed_window_matcher.sv */
// Top level of the keyed window matcher.
// Keyed window matcher. Words of kind load append a reference record to a
// 256-entry table (empty key: status loaded, nothing stored; full: status
// table full). A probe scans the table in load order and takes the first
// unused entry with equal key and amount whose stamp lies within
// time_window seconds; it is marked used. Clear empties the table. Kind 3
// words are taken and dropped without a result. A two-word queue sits
// between the input and the table engine. A load or clear holds the engine
// to take the word, then to present the result; a probe also holds it for
// a registered memory read, then a compare, per entry scanned, as set by
// the single memory read port. A result is valid at the earliest in the
// cycle after its word leaves the queue, which the input fills through a
// registered slot; out_stall holds the result. The user must write
// time_window only while idle; the block itself does not enforce it.
`default_nettype none
module keyed_window_matcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic        key_present,
  input  wire logic [63:0] ref_key,
  input  wire logic signed [47:0] amount,
  input  wire logic [39:0] stamp,
  input  wire logic [31:0] record_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      probe_id,
  output logic [31:0]      partner_id,
  output logic signed [47:0] match_amount,
  output logic [39:0]      time_delta
);
  logic [31:0] time_window;
  kwm_pkg::word_t in_word, q_word;
  kwm_pkg::result_t res;
  logic q_valid, q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_window <= kwm_pkg::WindowReset;
    end else if (cfg_we) begin
      time_window <= cfg_data;
    end
  end

  always_comb begin
    in_word.kind = kwm_pkg::kind_t'(kind);
    in_word.key_present = key_present;
    in_word.ref_key = ref_key;
    in_word.amount = amount;
    in_word.stamp = stamp;
    in_word.record_id = record_id;
  end

  kwm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
  );

  kwm_back u_back (
    .clk(clk), .rst(rst), .time_window(time_window), .q_valid(q_valid),
    .q_take(q_take), .q_word(q_word), .out_valid(out_valid),
    .out_stall(out_stall), .out_res(res)
  );

  assign status = res.status;
  assign probe_id = res.probe_id;
  assign partner_id = res.partner_id;
  assign match_amount = res.match_amount;
  assign time_delta = res.time_delta;
endmodule
`default_nettype wire
